FILE: sv/xil_pkg.sv
// Shared types, constants and opcode tables for the x86 instruction length predecoder.
`default_nettype none

package xil_pkg;

  localparam int unsigned WINDOW_BYTES = 15;
  localparam int unsigned POS_W        = 5;

  localparam logic [7:0] OP_ESCAPE   = 8'h0F;
  localparam logic [7:0] REX_NIBBLE  = 8'h40;
  localparam logic [7:0] HI_MASK     = 8'hF0;
  localparam logic [7:0] VEX_2BYTE   = 8'hC5;
  localparam logic [7:0] VEX_3BYTE   = 8'hC4;
  localparam logic [7:0] PFX_LOCK    = 8'hF0;

  localparam logic [POS_W-1:0] WINDOW_LEN = POS_W'(WINDOW_BYTES);

  typedef struct packed {
    logic [55:0] bytes_high;
    logic [63:0] bytes_low;
  } in_t;

  typedef struct packed {
    logic [3:0] length;
    logic       clamped;
    logic       modrm_seen;
    logic       escape_seen;
  } out_t;

  // Opcode location handed from the prefix stage to the sizing stage.
  typedef struct packed {
    logic             rex;
    logic             esc;
    logic [POS_W-1:0] op_end;
    logic [7:0]       opcode;
  } loc_t;

  // Read a window byte; positions at or past the window read as zero.
  function automatic logic [7:0] byte_at(input logic [8*WINDOW_BYTES-1:0] win,
                                         input logic [POS_W-1:0] idx);
    logic [255:0] ext;
    ext = {{(256 - 8*WINDOW_BYTES){1'b0}}, win};
    return ext[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic is_legacy_prefix(input logic [7:0] b);
    return b == PFX_LOCK || b == 8'hF2 || b == 8'hF3 || b == 8'h2E ||
           b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
           b == 8'h65 || b == 8'h66 || b == 8'h67;
  endfunction

  function automatic logic table_one(input logic [7:0] b);
    return b <= 8'h3F || (b >= 8'h88 && b <= 8'h8F) || (b >= 8'hD0 && b <= 8'hDF) ||
           b == 8'h62 || b == 8'h63 || b == 8'h69 || b == 8'h6B ||
           (b >= 8'h80 && b <= 8'h81) || (b >= 8'h83 && b <= 8'h87) ||
           b == 8'hC6 || b == 8'hC7 || b == 8'hF6 || b == 8'hF7 ||
           b == 8'hFE || b == 8'hFF || b == 8'hC0 || b == 8'hC1;
  endfunction

  function automatic logic table_two(input logic [7:0] b);
    return b <= 8'h7F || (b >= 8'h80 && b <= 8'h87) || (b >= 8'h8C && b <= 8'h8F) ||
           (b >= 8'h90 && b <= 8'h9F) || (b >= 8'hA4 && b <= 8'hAF) ||
           (b >= 8'hB0 && b <= 8'hB7);
  endfunction

endpackage

`default_nettype wire

FILE: sv/xil_locate.sv
// Prefix scan, REX and VEX skip, and opcode location for one code window.
`default_nettype none

module xil_locate (
  input  wire logic [8*xil_pkg::WINDOW_BYTES-1:0] win,
  input  wire logic                               long_mode,
  output xil_pkg::loc_t                           loc
);

  logic [xil_pkg::WINDOW_BYTES-1:0] pfx;
  logic [xil_pkg::POS_W-1:0]        npfx;
  logic [xil_pkg::POS_W-1:0]        pos_rex;
  logic [xil_pkg::POS_W-1:0]        pos_vex;
  logic [xil_pkg::POS_W-1:0]        pos_op;
  logic [7:0]                       b_rex;
  logic [7:0]                       b_vex;
  logic [7:0]                       b_op;
  logic                             rex;
  logic                             esc;

  // Flag every prefix byte, then find the first byte that is not one.
  always_comb begin
    for (int i = 0; i < xil_pkg::WINDOW_BYTES; i++) begin
      pfx[i] = xil_pkg::is_legacy_prefix(win[8*i +: 8]);
    end
    npfx = xil_pkg::WINDOW_LEN;
    for (int i = xil_pkg::WINDOW_BYTES - 1; i >= 0; i--) begin
      if (!pfx[i]) begin
        npfx = xil_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    b_rex   = xil_pkg::byte_at(win, npfx);
    rex     = long_mode && ((b_rex & xil_pkg::HI_MASK) == xil_pkg::REX_NIBBLE);
    pos_rex = npfx + xil_pkg::POS_W'(rex);

    // Skip the VEX payload only when it still fits inside the window.
    b_vex = xil_pkg::byte_at(win, pos_rex);
    if (b_vex == xil_pkg::VEX_2BYTE && (pos_rex + 5'd1) < xil_pkg::WINDOW_LEN) begin
      pos_vex = pos_rex + 5'd1;
    end else if (b_vex == xil_pkg::VEX_3BYTE &&
                 (pos_rex + 5'd2) < xil_pkg::WINDOW_LEN) begin
      pos_vex = pos_rex + 5'd2;
    end else begin
      pos_vex = pos_rex;
    end

    b_op   = xil_pkg::byte_at(win, pos_vex);
    esc    = (b_op == xil_pkg::OP_ESCAPE);
    pos_op = esc ? pos_vex + 5'd2 : pos_vex + 5'd1;

    loc.rex    = rex;
    loc.esc    = esc;
    loc.op_end = pos_op;
    loc.opcode = xil_pkg::byte_at(win, pos_op - 5'd1);
  end

endmodule

`default_nettype wire

FILE: sv/xil_size.sv
// ModRM, SIB, displacement and immediate sizing, with the length clamp.
`default_nettype none

module xil_size (
  input  wire logic [8*xil_pkg::WINDOW_BYTES-1:0] win,
  input  wire logic                               long_mode,
  input  wire xil_pkg::loc_t                      loc,
  output xil_pkg::out_t                           res
);

  logic [7:0]                m;
  logic [7:0]                sib;
  logic [1:0]                md;
  logic [2:0]                rm;
  logic                      modrm_p;
  logic                      has_sib;
  logic [xil_pkg::POS_W-1:0] sib_pos;
  logic [xil_pkg::POS_W-1:0] extra;
  logic [xil_pkg::POS_W-1:0] len;
  logic [7:0]                b;

  always_comb begin
    b       = loc.opcode;
    modrm_p = xil_pkg::table_one(b) || (loc.esc && xil_pkg::table_two(b));
    m       = xil_pkg::byte_at(win, loc.op_end);
    md      = m[7:6];
    rm      = m[2:0];
    sib_pos = loc.op_end + 5'd1;
    sib     = xil_pkg::byte_at(win, sib_pos);
    has_sib = (md != 2'd3) && (rm == 3'd4);
    extra   = '0;

    if (modrm_p) begin
      extra = 5'd1;
      if (has_sib) begin
        extra = extra + 5'd1;
        if (md == 2'd0 && sib[2:0] == 3'd5) begin
          extra = extra + 5'd4;
        end
      end
      if (md == 2'd1) begin
        extra = extra + 5'd1;
      end else if (md == 2'd2) begin
        extra = extra + 5'd4;
      end else if (md == 2'd0 && rm == 3'd5) begin
        extra = extra + 5'd4;
      end

      if (b == 8'h80 || b == 8'h83 || b == 8'hC6 || b == 8'hF6) begin
        extra = extra + 5'd1;
      end else if (b == 8'h81 || b == 8'hC7) begin
        extra = extra + 5'd4;
      end else if (b == 8'hF7 && m[5:3] == 3'd0) begin
        extra = extra + 5'd4;
      end
    end else begin
      if (b == 8'h68 || b == 8'hA9 || b == 8'hE8 || b == 8'hE9) begin
        extra = 5'd4;
      end else if (b == 8'h6A || b == 8'hA8 || b == 8'hCD || b == 8'hEB ||
                   (b >= 8'h70 && b <= 8'h7F) || (b >= 8'hB0 && b <= 8'hB7)) begin
        extra = 5'd1;
      end else if (b >= 8'hA0 && b <= 8'hA3) begin
        extra = long_mode ? 5'd8 : 5'd4;
      end else if (b >= 8'hB8 && b <= 8'hBF) begin
        extra = (long_mode && loc.rex) ? 5'd8 : 5'd4;
      end else if (b == 8'hC2) begin
        extra = 5'd2;
      end
    end

    len = loc.op_end + extra;

    res.clamped     = (len > xil_pkg::WINDOW_LEN);
    res.length      = res.clamped ? 4'd1 : len[3:0];
    res.modrm_seen  = modrm_p;
    res.escape_seen = loc.esc;
  end

endmodule

`default_nettype wire

FILE: sv/x86_instruction_length_top.sv
// Top level of the x86 instruction length predecoder: word registers and config.
// Pipeline: the edge that accepts start loads the window register, then the result
//   register takes the decoded length after one pass of decode logic between them;
//   done rises when the result register is loaded.
// Throughput: one word per cycle; busy stays low, so start may be high every cycle.
// Reset: synchronous active-high rst clears the pipeline valids and sets long_mode to 1.
// The receiver cannot stall: each result shows for one cycle, marked by done.
`default_nettype none

module x86_instruction_length_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire xil_pkg::in_t  item,
  input  wire logic          cfg_we,
  input  wire logic          cfg_data,
  output logic               done,
  output xil_pkg::out_t      result
);

  // Config register: 1 decodes 64-bit code with REX, 0 decodes 32-bit code.
  logic long_mode;

  // Window register: hold the accepted word for one decode pass.
  logic                               win_valid;
  logic [8*xil_pkg::WINDOW_BYTES-1:0] win;

  // Result register: holds the output word; done marks it for exactly one cycle.
  logic          res_valid;
  xil_pkg::out_t res;

  xil_pkg::loc_t loc;
  xil_pkg::out_t res_next;

  // No internal backpressure: every start is taken.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_mode <= 1'b1;
    end else if (cfg_we) begin
      long_mode <= cfg_data;
    end
  end

  // Advance the valid bits every cycle; a slot empties unless a new word lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      win_valid <= start && !busy;
      res_valid <= win_valid;
    end
  end

  // Payload registers carry no reset; the valids qualify them.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      win <= {item.bytes_high, item.bytes_low};
    end
    if (win_valid) begin
      res <= res_next;
    end
  end

  // Skip prefixes, REX and VEX, and find the opcode byte.
  xil_locate u_locate (
    .win       (win),
    .long_mode (long_mode),
    .loc       (loc)
  );

  // Add ModRM, SIB, displacement and immediate sizes; clamp past the window.
  xil_size u_size (
    .win       (win),
    .long_mode (long_mode),
    .loc       (loc),
    .res       (res_next)
  );

  assign done   = res_valid;
  assign result = res;

endmodule

`default_nettype wire
